FILE: rtl/core/gqi_pkg.sv
// Shared types, codes and constants of the gyro quaternion integrator.
`default_nettype none

package gqi_pkg;

    // Default fraction bits of the attitude words (Q2.30)
    localparam int QUAT_FRAC_BITS_DEF = 30;
    // Reset value of the angle scale, 8.75 mdps per count in Q0.48
    localparam logic [31:0] ANGLE_SCALE_RESET = 32'd42986000;
    // Steps of the bit-pair square root over a 64-bit sum
    localparam int SQRT_STEPS = 32;
    localparam int ITER_W = 6;

    typedef struct packed {
        logic signed [15:0] rate_x_raw;
        logic signed [15:0] rate_y_raw;
        logic signed [15:0] rate_z_raw;
        logic [15:0]        elapsed_ms;
    } gqi_in_t;

    typedef struct packed {
        logic signed [31:0] att_w;
        logic signed [31:0] att_x;
        logic signed [31:0] att_y;
        logic signed [31:0] att_z;
        logic               degenerate;
    } gqi_out_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MCM,
        OP_MAS,
        OP_HALF,
        OP_MQH,
        OP_ACQ,
        OP_PFIN,
        OP_MAG,
        OP_SHR,
        OP_SHL,
        OP_MSQ,
        OP_ACS,
        OP_SQI,
        OP_SQS,
        OP_SQF,
        OP_DVI,
        OP_DVS,
        OP_DVF,
        OP_IDENT,
        OP_OUT
    } gqi_op_t;

    typedef struct packed {
        gqi_op_t    op;
        logic [1:0] sel;
        logic [1:0] term;
    } gqi_cmd_t;

    typedef struct packed {
        logic mx_big;
        logic mx_low;
        logic degen_cond;
        logic out_busy;
    } gqi_status_t;

    typedef struct packed {
        logic [1:0] qs;
        logic [1:0] hs;
        logic       neg;
    } gqi_term_t;

    // Operand selection of the quaternion product q (x) (0, h)
    function automatic gqi_term_t term_sel(input logic [1:0] comp, input logic [1:0] term);
        gqi_term_t t;
        t = '{qs: 2'd0, hs: 2'd0, neg: 1'b0};
        case ({comp, term})
            4'b00_00: t = '{qs: 2'd1, hs: 2'd0, neg: 1'b1};
            4'b00_01: t = '{qs: 2'd2, hs: 2'd1, neg: 1'b1};
            4'b00_10: t = '{qs: 2'd3, hs: 2'd2, neg: 1'b1};
            4'b01_00: t = '{qs: 2'd0, hs: 2'd0, neg: 1'b0};
            4'b01_01: t = '{qs: 2'd2, hs: 2'd2, neg: 1'b0};
            4'b01_10: t = '{qs: 2'd3, hs: 2'd1, neg: 1'b1};
            4'b10_00: t = '{qs: 2'd0, hs: 2'd1, neg: 1'b0};
            4'b10_01: t = '{qs: 2'd1, hs: 2'd2, neg: 1'b1};
            4'b10_10: t = '{qs: 2'd3, hs: 2'd0, neg: 1'b0};
            4'b11_00: t = '{qs: 2'd0, hs: 2'd2, neg: 1'b0};
            4'b11_01: t = '{qs: 2'd1, hs: 2'd1, neg: 1'b0};
            4'b11_10: t = '{qs: 2'd2, hs: 2'd0, neg: 1'b1};
            default:  t = '{qs: 2'd0, hs: 2'd0, neg: 1'b0};
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gyro_quaternion_integrator_unit.sv
// Top level of the gyro quaternion integrator: sequencer plus datapath.
//
// Usage: each request on the input channel (in_valid/in_ready, payload in_data)
// carries three raw gyro counts and the elapsed milliseconds. The block rotates
// its stored attitude quaternion by the first-order update, renormalizes it and
// returns one result on the output channel (out_valid/out_ready, out_data).
// One request is worked at a time. A vector that has to be shifted down skips
// the degeneracy test, and a degenerate vector ends early with identity. The
// work is shared by the 33x33 multiplier, the one-bit-per-cycle square root
// (32 steps) and the one-bit-per-cycle divider (QUAT_FRAC_BITS+2 steps for
// each of four components).
// The result sits in an output register, so in_ready returns as soon as it is
// written; if the receiver stalls, the next request is worked but its result
// waits until the previous one has been taken.
// Reset sets the attitude to identity, the angle scale to 8.75 mdps per count
// and drops any pending result. cfg_we writes the angle scale at once.
`default_nettype none

module gyro_quaternion_integrator_unit #(
    parameter int QUAT_FRAC_BITS = gqi_pkg::QUAT_FRAC_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire gqi_pkg::gqi_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output gqi_pkg::gqi_out_t      out_data,
    input  wire logic              cfg_we,
    input  wire logic [31:0]       cfg_wdata
);

    gqi_pkg::gqi_cmd_t    cmd;
    gqi_pkg::gqi_status_t status;

    // Sequence the update
    gqi_ctrl #(
        .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Compute the update
    gqi_dp #(
        .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

FILE: rtl/core/gqi_ctrl.sv
// Sequencer of the gyro quaternion integrator: issues at most one datapath command a cycle.
`default_nettype none

module gqi_ctrl #(
    parameter int QUAT_FRAC_BITS = gqi_pkg::QUAT_FRAC_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire gqi_pkg::gqi_status_t status,
    output gqi_pkg::gqi_cmd_t        cmd
);

    localparam int QW = QUAT_FRAC_BITS + 2;

    typedef enum logic [22:0] {
        S_IDLE  = 23'd1 << 0,
        S_HCM   = 23'd1 << 1,
        S_HAS   = 23'd1 << 2,
        S_HFIN  = 23'd1 << 3,
        S_QMUL  = 23'd1 << 4,
        S_QACC  = 23'd1 << 5,
        S_QFIN  = 23'd1 << 6,
        S_MAG   = 23'd1 << 7,
        S_MCHK  = 23'd1 << 8,
        S_TSQ   = 23'd1 << 9,
        S_TAC   = 23'd1 << 10,
        S_TCHK  = 23'd1 << 11,
        S_LCHK  = 23'd1 << 12,
        S_NSQ   = 23'd1 << 13,
        S_NAC   = 23'd1 << 14,
        S_SQI   = 23'd1 << 15,
        S_SQS   = 23'd1 << 16,
        S_SQF   = 23'd1 << 17,
        S_DVI   = 23'd1 << 18,
        S_DVS   = 23'd1 << 19,
        S_DVF   = 23'd1 << 20,
        S_IDENT = 23'd1 << 21,
        S_OUT   = 23'd1 << 22
    } state_t;

    state_t                        state_reg, state_next;
    logic [1:0]                    sel_reg, sel_next;
    logic [1:0]                    term_reg, term_next;
    logic [gqi_pkg::ITER_W-1:0]    iter_reg, iter_next;
    logic                          shifted_reg, shifted_next;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            sel_reg     <= 2'd0;
            term_reg    <= 2'd0;
            iter_reg    <= '0;
            shifted_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            term_reg    <= term_next;
            iter_reg    <= iter_next;
            shifted_reg <= shifted_next;
        end
    end

    // Advance the sequence and issue commands
    always_comb
    begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        term_next    = term_reg;
        iter_next    = iter_reg;
        shifted_next = shifted_reg;
        in_ready     = 1'b0;
        cmd.op       = gqi_pkg::OP_NONE;
        cmd.sel      = sel_reg;
        cmd.term     = term_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = gqi_pkg::OP_LOAD;
                    sel_next   = 2'd0;
                    state_next = S_HCM;
                end
            end
            S_HCM:
            begin
                cmd.op     = gqi_pkg::OP_MCM;
                state_next = S_HAS;
            end
            S_HAS:
            begin
                cmd.op     = gqi_pkg::OP_MAS;
                state_next = S_HFIN;
            end
            S_HFIN:
            begin
                cmd.op = gqi_pkg::OP_HALF;
                if (sel_reg == 2'd2)
                begin
                    sel_next   = 2'd0;
                    term_next  = 2'd0;
                    state_next = S_QMUL;
                end
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = S_HCM;
                end
            end
            S_QMUL:
            begin
                cmd.op     = gqi_pkg::OP_MQH;
                state_next = S_QACC;
            end
            S_QACC:
            begin
                cmd.op = gqi_pkg::OP_ACQ;
                if (term_reg == 2'd2)
                begin
                    state_next = S_QFIN;
                end
                else
                begin
                    term_next  = term_reg + 2'd1;
                    state_next = S_QMUL;
                end
            end
            S_QFIN:
            begin
                cmd.op    = gqi_pkg::OP_PFIN;
                term_next = 2'd0;
                if (sel_reg == 2'd3)
                begin
                    state_next = S_MAG;
                end
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = S_QMUL;
                end
            end
            S_MAG:
            begin
                cmd.op       = gqi_pkg::OP_MAG;
                shifted_next = 1'b0;
                state_next   = S_MCHK;
            end
            S_MCHK:
            begin
                sel_next = 2'd0;
                if (status.mx_big)
                begin
                    cmd.op       = gqi_pkg::OP_SHR;
                    shifted_next = 1'b1;
                end
                else if (shifted_reg)
                begin
                    state_next = S_NSQ;
                end
                else
                begin
                    state_next = S_TSQ;
                end
            end
            S_TSQ:
            begin
                cmd.op     = gqi_pkg::OP_MSQ;
                state_next = S_TAC;
            end
            S_TAC:
            begin
                cmd.op = gqi_pkg::OP_ACS;
                if (sel_reg == 2'd3)
                begin
                    state_next = S_TCHK;
                end
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = S_TSQ;
                end
            end
            S_TCHK:
            begin
                state_next = status.degen_cond ? S_IDENT : S_LCHK;
            end
            S_LCHK:
            begin
                sel_next = 2'd0;
                if (status.mx_low)
                begin
                    cmd.op = gqi_pkg::OP_SHL;
                end
                else
                begin
                    state_next = S_NSQ;
                end
            end
            S_NSQ:
            begin
                cmd.op     = gqi_pkg::OP_MSQ;
                state_next = S_NAC;
            end
            S_NAC:
            begin
                cmd.op = gqi_pkg::OP_ACS;
                if (sel_reg == 2'd3)
                begin
                    state_next = S_SQI;
                end
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = S_NSQ;
                end
            end
            S_SQI:
            begin
                cmd.op     = gqi_pkg::OP_SQI;
                iter_next  = '0;
                state_next = S_SQS;
            end
            S_SQS:
            begin
                cmd.op = gqi_pkg::OP_SQS;
                if (iter_reg == gqi_pkg::ITER_W'(gqi_pkg::SQRT_STEPS - 1))
                begin
                    state_next = S_SQF;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            S_SQF:
            begin
                cmd.op     = gqi_pkg::OP_SQF;
                sel_next   = 2'd0;
                state_next = S_DVI;
            end
            S_DVI:
            begin
                cmd.op     = gqi_pkg::OP_DVI;
                iter_next  = '0;
                state_next = S_DVS;
            end
            S_DVS:
            begin
                cmd.op = gqi_pkg::OP_DVS;
                if (iter_reg == gqi_pkg::ITER_W'(QW - 1))
                begin
                    state_next = S_DVF;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            S_DVF:
            begin
                cmd.op = gqi_pkg::OP_DVF;
                if (sel_reg == 2'd3)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = S_DVI;
                end
            end
            S_IDENT:
            begin
                cmd.op     = gqi_pkg::OP_IDENT;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = gqi_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/gqi_dp.sv
// Datapath of the gyro quaternion integrator: shared multiplier, root and divider.
`default_nettype none

module gqi_dp #(
    parameter int QUAT_FRAC_BITS = gqi_pkg::QUAT_FRAC_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire gqi_pkg::gqi_cmd_t    cmd,
    output gqi_pkg::gqi_status_t      status,
    input  wire gqi_pkg::gqi_in_t     in_data,
    input  wire logic                 cfg_we,
    input  wire logic [31:0]          cfg_wdata,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output gqi_pkg::gqi_out_t         out_data
);

    localparam int F  = QUAT_FRAC_BITS;
    localparam int QW = F + 2;
    localparam int HS = 49 - F;
    localparam logic [63:0] HALF_RND = 64'd1 << (48 - F);
    localparam logic [65:0] ACC_RND  = 66'd1 << (F - 1);
    localparam logic [63:0] THR =
        64'(((64'd1 << (2 * F)) + 64'd500000000000) / 64'd1000000000000);
    localparam logic [QW-1:0] ONE_Q = QW'(1) << F;
    localparam logic signed [31:0] ONE_W = 32'sd1 <<< F;

    logic [31:0]         scale_reg;
    logic [16:0]         cnt_abs_reg [3];
    logic                cnt_neg_reg [3];
    logic [15:0]         ms_reg;
    logic signed [31:0]  h_reg [3];
    logic signed [31:0]  q_reg [4];
    logic signed [65:0]  prod_reg;
    logic signed [65:0]  acc_reg;
    logic signed [35:0]  p_reg [4];
    logic [34:0]         mag_reg [4];
    logic [34:0]         mx_reg;
    logic [63:0]         sum_reg;
    logic [63:0]         srem_reg, sroot_reg, sbit_reg;
    logic [32:0]         n_reg;
    logic [32:0]         drem_reg;
    logic [QW-1:0]       dnum_reg, quo_reg;
    logic                degen_reg;
    logic                out_valid_reg;
    gqi_pkg::gqi_out_t   out_data_reg;

    gqi_pkg::gqi_term_t  tt;
    logic signed [32:0]  ma, mb;
    logic signed [65:0]  mul_full;
    logic [63:0]         hrnd;
    logic [30:0]         hsat;
    logic signed [31:0]  hpos, hval;
    logic signed [65:0]  tprod;
    logic [65:0]         amag, arnd;
    logic signed [35:0]  rs_pos, rs_val;
    logic [34:0]         pm [4];
    logic [34:0]         mx01, mx23, mx_all;
    logic [63:0]         strial;
    logic [63:0]         num;
    logic [33:0]         dt;
    logic                dge;
    logic [QW-1:0]       qv;
    logic signed [31:0]  qpos;
    logic signed [16:0]  cx [3];

    assign tt = gqi_pkg::term_sel(cmd.sel, cmd.term);

    // Select multiplier operands
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            gqi_pkg::OP_MCM:
            begin
                ma = {16'd0, cnt_abs_reg[cmd.sel]};
                mb = {17'd0, ms_reg};
            end
            gqi_pkg::OP_MAS:
            begin
                ma = {1'b0, prod_reg[31:0]};
                mb = {1'b0, scale_reg};
            end
            gqi_pkg::OP_MQH:
            begin
                ma = {q_reg[tt.qs][31], q_reg[tt.qs]};
                mb = {h_reg[tt.hs][31], h_reg[tt.hs]};
            end
            gqi_pkg::OP_MSQ:
            begin
                ma = {2'd0, mag_reg[cmd.sel][30:0]};
                mb = {2'd0, mag_reg[cmd.sel][30:0]};
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign mul_full = ma * mb;

    // Round and saturate the half angle
    assign hrnd = (prod_reg[63:0] + HALF_RND) >> HS;
    assign hsat = (hrnd > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : hrnd[30:0];
    assign hpos = {1'b0, hsat};
    assign hval = cnt_neg_reg[cmd.sel] ? -hpos : hpos;

    // Signed product term and rounded sum
    assign tprod  = tt.neg ? -prod_reg : prod_reg;
    assign amag   = acc_reg[65] ? 66'(-acc_reg) : 66'(acc_reg);
    assign arnd   = (amag + ACC_RND) >> F;
    assign rs_pos = {1'b0, arnd[34:0]};
    assign rs_val = acc_reg[65] ? -rs_pos : rs_pos;

    // Magnitudes and their maximum
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pm[i] = p_reg[i][35] ? 35'(-p_reg[i]) : p_reg[i][34:0];
        end
        mx01   = (pm[0] > pm[1]) ? pm[0] : pm[1];
        mx23   = (pm[2] > pm[3]) ? pm[2] : pm[3];
        mx_all = (mx01 > mx23) ? mx01 : mx23;
    end

    // Square root trial, division step and clamp
    assign strial = sroot_reg + sbit_reg;
    assign num    = (64'(mag_reg[cmd.sel][30:0]) << F) + 64'(n_reg >> 1);
    assign dt     = {drem_reg, dnum_reg[QW-1]};
    assign dge    = (dt >= {1'b0, n_reg});
    assign qv     = (quo_reg > ONE_Q) ? ONE_Q : quo_reg;
    assign qpos   = 32'(qv);

    always_comb
    begin
        cx[0] = {in_data.rate_x_raw[15], in_data.rate_x_raw};
        cx[1] = {in_data.rate_y_raw[15], in_data.rate_y_raw};
        cx[2] = {in_data.rate_z_raw[15], in_data.rate_z_raw};
    end

    // Hold configuration, attitude and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= gqi_pkg::ANGLE_SCALE_RESET;
            q_reg[0]      <= ONE_W;
            q_reg[1]      <= '0;
            q_reg[2]      <= '0;
            q_reg[3]      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                scale_reg <= cfg_wdata;
            end
            if (cmd.op == gqi_pkg::OP_DVF)
            begin
                q_reg[cmd.sel] <= p_reg[cmd.sel][35] ? -qpos : qpos;
            end
            else if (cmd.op == gqi_pkg::OP_IDENT)
            begin
                q_reg[0] <= ONE_W;
                q_reg[1] <= '0;
                q_reg[2] <= '0;
                q_reg[3] <= '0;
            end
            if (cmd.op == gqi_pkg::OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Execute datapath commands
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full;
        unique case (cmd.op)
            gqi_pkg::OP_NONE: ;
            gqi_pkg::OP_LOAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    cnt_neg_reg[i] <= cx[i][16];
                    cnt_abs_reg[i] <= cx[i][16] ? 17'(-cx[i]) : 17'(cx[i]);
                end
                ms_reg    <= in_data.elapsed_ms;
                degen_reg <= 1'b0;
            end
            gqi_pkg::OP_MCM: ;
            gqi_pkg::OP_MAS: ;
            gqi_pkg::OP_HALF:  h_reg[cmd.sel] <= hval;
            gqi_pkg::OP_MQH: ;
            gqi_pkg::OP_ACQ:   acc_reg <= (cmd.term == 2'd0) ? tprod : acc_reg + tprod;
            gqi_pkg::OP_PFIN:
            begin
                p_reg[cmd.sel] <= {{4{q_reg[cmd.sel][31]}}, q_reg[cmd.sel]} + rs_val;
            end
            gqi_pkg::OP_MAG:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    mag_reg[i] <= pm[i];
                end
                mx_reg <= mx_all;
            end
            gqi_pkg::OP_SHR:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    mag_reg[i] <= mag_reg[i] >> 1;
                end
                mx_reg <= mx_reg >> 1;
            end
            gqi_pkg::OP_SHL:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    mag_reg[i] <= mag_reg[i] << 1;
                end
                mx_reg <= mx_reg << 1;
            end
            gqi_pkg::OP_MSQ: ;
            gqi_pkg::OP_ACS:
            begin
                sum_reg <= (cmd.sel == 2'd0) ? prod_reg[63:0] : sum_reg + prod_reg[63:0];
            end
            gqi_pkg::OP_SQI:
            begin
                srem_reg  <= sum_reg;
                sroot_reg <= '0;
                sbit_reg  <= 64'd1 << 62;
            end
            gqi_pkg::OP_SQS:
            begin
                if (srem_reg >= strial)
                begin
                    srem_reg  <= srem_reg - strial;
                    sroot_reg <= (sroot_reg >> 1) + sbit_reg;
                end
                else
                begin
                    sroot_reg <= sroot_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            gqi_pkg::OP_SQF:
            begin
                n_reg <= 33'(sroot_reg) + 33'(srem_reg > sroot_reg);
            end
            gqi_pkg::OP_DVI:
            begin
                dnum_reg <= num[QW-1:0];
                drem_reg <= 33'(num >> QW);
                quo_reg  <= '0;
            end
            gqi_pkg::OP_DVS:
            begin
                drem_reg <= dge ? 33'(dt - {1'b0, n_reg}) : dt[32:0];
                dnum_reg <= dnum_reg << 1;
                quo_reg  <= {quo_reg[QW-2:0], dge};
            end
            gqi_pkg::OP_DVF: ;
            gqi_pkg::OP_IDENT: degen_reg <= 1'b1;
            gqi_pkg::OP_OUT:
            begin
                out_data_reg.att_w      <= q_reg[0];
                out_data_reg.att_x      <= q_reg[1];
                out_data_reg.att_y      <= q_reg[2];
                out_data_reg.att_z      <= q_reg[3];
                out_data_reg.degenerate <= degen_reg;
            end
            default: ;
        endcase
    end

    // Report status
    assign status.mx_big     = |mx_reg[34:31];
    assign status.mx_low     = ~|mx_reg[34:30];
    assign status.degen_cond = (sum_reg < THR) || (mx_reg == '0);
    assign status.out_busy   = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/gqi_checker.sv
// Port-level checks of the gyro quaternion integrator and their bind.
`default_nettype none

module gqi_checker #(
    parameter int QUAT_FRAC_BITS = gqi_pkg::QUAT_FRAC_BITS_DEF
) (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire gqi_pkg::gqi_in_t  in_data,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire gqi_pkg::gqi_out_t out_data
);

    localparam logic signed [31:0] ONE_W = 32'sd1 <<< QUAT_FRAC_BITS;

    // Hold a stalled input request
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input request dropped while stalled");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Drop ready while a request is being worked
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken during an update");

    // Drop valid after a result is taken
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("result repeated");

    // Degenerate results carry identity
    a_degen_ident: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.degenerate |-> out_data.att_w == ONE_W &&
        out_data.att_x == 32'sd0 && out_data.att_y == 32'sd0 && out_data.att_z == 32'sd0)
        else $error("degenerate result is not identity");

endmodule

bind gyro_quaternion_integrator_unit gqi_checker #(
    .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
) u_gqi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

FILE: tb/gyro_quaternion_integrator_unit_tb.sv
// Testbench of the gyro quaternion integrator: directed table, random samples, attitude predictor.
`default_nettype none

module gyro_quaternion_integrator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = gqi_pkg::QUAT_FRAC_BITS_DEF;
    localparam longint ONE_Q = 64'sd1 << FRAC;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 600;

    // Idle phases: percent of cycles each side holds off
    typedef enum int {PH_NONE, PH_SEND, PH_RECV, PH_BOTH} idle_phase_t;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    gqi_pkg::gqi_in_t in_data;
    gqi_pkg::gqi_out_t out_data;
    logic cfg_we;
    logic [31:0] cfg_wdata;

    gyro_quaternion_integrator_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // Predictor state
    logic [31:0] pred_scale;
    logic signed [31:0] pred_att [4];
    gqi_pkg::gqi_out_t expected_att_q [$];
    int errors;
    int cycles;
    int send_idle_pct, recv_idle_pct;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("gyro_quaternion_integrator_unit test failed");
            $finish;
        end
    end

    function automatic longint round_q(input longint v);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint half_angle(input logic signed [15:0] cnt, input logic [15:0] ms);
        logic [63:0] mag;
        longint c;
        c = cnt;
        mag = 64'((c < 0) ? -c : c) * 64'(ms) * 64'(pred_scale);
        mag = (mag + (64'd1 << (48 - FRAC))) >> (49 - FRAC);
        if (mag > 64'h7FFF_FFFF)
            mag = 64'h7FFF_FFFF;
        return (c < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic [63:0] isqrt_round(input logic [63:0] s);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        if (s > r)
            r = r + 1;
        return r;
    endfunction

    // Advance the predicted attitude by one sample and return the result
    function automatic gqi_pkg::gqi_out_t integrate_sample(input gqi_pkg::gqi_in_t s);
        longint hx, hy, hz, w, x, y, z;
        longint p [4];
        logic [63:0] mag [4];
        logic [63:0] mx, sum, thr, n, qv;
        logic degen;
        gqi_pkg::gqi_out_t r;
        hx = half_angle(s.rate_x_raw, s.elapsed_ms);
        hy = half_angle(s.rate_y_raw, s.elapsed_ms);
        hz = half_angle(s.rate_z_raw, s.elapsed_ms);
        w = pred_att[0]; x = pred_att[1]; y = pred_att[2]; z = pred_att[3];
        p[0] = w + round_q(-x * hx - y * hy - z * hz);
        p[1] = x + round_q(w * hx + y * hz - z * hy);
        p[2] = y + round_q(w * hy - x * hz + z * hx);
        p[3] = z + round_q(w * hz + x * hy - y * hx);
        mx = 0;
        degen = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = (p[i] < 0) ? 64'(-p[i]) : 64'(p[i]);
            if (mag[i] > mx)
                mx = mag[i];
        end
        if (mx >= (64'd1 << 31))
        begin
            while (mx >= (64'd1 << 31))
            begin
                mx = mx >> 1;
                for (int i = 0; i < 4; i++)
                    mag[i] = mag[i] >> 1;
            end
        end
        else
        begin
            thr = ((64'd1 << (2 * FRAC)) + 64'd500000000000) / 64'd1000000000000;
            sum = 0;
            for (int i = 0; i < 4; i++)
                sum = sum + mag[i] * mag[i];
            if (sum < thr || mx == 0)
                degen = 1'b1;
            else
                while (mx < (64'd1 << 30))
                begin
                    mx = mx << 1;
                    for (int i = 0; i < 4; i++)
                        mag[i] = mag[i] << 1;
                end
        end
        if (degen)
        begin
            pred_att[0] = 32'(ONE_Q);
            for (int i = 1; i < 4; i++)
                pred_att[i] = 0;
        end
        else
        begin
            sum = 0;
            for (int i = 0; i < 4; i++)
                sum = sum + mag[i] * mag[i];
            n = isqrt_round(sum);
            for (int i = 0; i < 4; i++)
            begin
                qv = ((mag[i] << FRAC) + (n >> 1)) / n;
                if (qv > 64'(ONE_Q))
                    qv = 64'(ONE_Q);
                pred_att[i] = (p[i] < 0) ? -32'(qv) : 32'(qv);
            end
        end
        r.att_w = pred_att[0];
        r.att_x = pred_att[1];
        r.att_y = pred_att[2];
        r.att_z = pred_att[3];
        r.degenerate = degen;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Check each taken result against the oldest expectation
    always @(posedge clk)
    begin
        gqi_pkg::gqi_out_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_att_q.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                e = expected_att_q.pop_front();
                if (out_data.att_w !== e.att_w)
                    report_mismatch("att_w", out_data.att_w, e.att_w);
                if (out_data.att_x !== e.att_x)
                    report_mismatch("att_x", out_data.att_x, e.att_x);
                if (out_data.att_y !== e.att_y)
                    report_mismatch("att_y", out_data.att_y, e.att_y);
                if (out_data.att_z !== e.att_z)
                    report_mismatch("att_z", out_data.att_z, e.att_z);
                if (out_data.degenerate !== e.degenerate)
                    report_mismatch("degenerate", out_data.degenerate, e.degenerate);
            end
        end
    end

    // Receiver stalls, drawn at the falling edge
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic gqi_pkg::gqi_in_t rand_sample();
        gqi_pkg::gqi_in_t s;
        case ($urandom_range(3))
            0: s = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
            default:
            begin
                // Mostly small rotations and short intervals, as in use
                s.rate_x_raw = 16'($signed($urandom_range(4000)) - 2000);
                s.rate_y_raw = 16'($signed($urandom_range(4000)) - 2000);
                s.rate_z_raw = 16'($signed($urandom_range(4000)) - 2000);
                s.elapsed_ms = 16'($urandom_range(20));
            end
        endcase
        return s;
    endfunction

    // Present one request and hold it until it is accepted
    task automatic send_request(input gqi_pkg::gqi_in_t s, input logic check_it,
                                input gqi_pkg::gqi_out_t want);
        gqi_pkg::gqi_out_t e;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_valid <= 1'b1;
        in_data <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        e = integrate_sample(s);
        if (check_it && e !== want)
            report_mismatch("predictor vs table", e.att_w, want.att_w);
        expected_att_q.push_back(e);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (expected_att_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_scale(input logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        pred_scale = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    typedef struct {
        gqi_pkg::gqi_in_t s;
        logic check_it;
        gqi_pkg::gqi_out_t want;
    } stim_row_t;

    localparam gqi_pkg::gqi_out_t IDENT_R = '{att_w: 32'sd1 << FRAC, att_x: 0, att_y: 0,
                                              att_z: 0, degenerate: 1'b0};

    stim_row_t dir_rows [$];
    logic [31:0] scales [5];

    initial
    begin
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        pred_scale = gqi_pkg::ANGLE_SCALE_RESET;
        pred_att[0] = 32'(ONE_Q);
        for (int i = 1; i < 4; i++)
            pred_att[i] = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero time and zero rate leave identity; extremes saturate
        dir_rows.push_back('{'{0, 0, 0, 0}, 1'b1, IDENT_R});
        dir_rows.push_back('{'{16'sh7FFF, 0, 0, 0}, 1'b1, IDENT_R});
        dir_rows.push_back('{'{0, 0, 0, 16'hFFFF}, 1'b1, IDENT_R});
        dir_rows.push_back('{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF}, 1'b0, IDENT_R});
        dir_rows.push_back('{'{-16'sh8000, -16'sh8000, -16'sh8000, 16'hFFFF}, 1'b0, IDENT_R});
        dir_rows.push_back('{'{16'sh7FFF, -16'sh8000, 16'sh0001, 16'd1}, 1'b0, IDENT_R});
        dir_rows.push_back('{'{-16'sh0001, 16'sh0000, 16'sh7FFF, 16'd10}, 1'b0, IDENT_R});
        dir_rows.push_back('{'{16'sh1234, 16'sh0F00, -16'sh0800, 16'd100}, 1'b0, IDENT_R});
        dir_rows.push_back('{'{0, 0, 0, 16'd5}, 1'b0, IDENT_R});
        dir_rows.push_back('{'{16'sh4000, 16'sh4000, 16'sh4000, 16'd1000}, 1'b0, IDENT_R});
        foreach (dir_rows[i])
            send_request(dir_rows[i].s, dir_rows[i].check_it, dir_rows[i].want);
        wait_idle();

        // Scale extremes: zero scale holds attitude; full scale gives huge angles
        scales = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd429860000, gqi_pkg::ANGLE_SCALE_RESET};
        for (int k = 0; k < 5; k++)
        begin
            write_scale(scales[k]);
            send_request('{16'sh7FFF, -16'sh8000, 16'sh1000, 16'hFFFF}, 1'b0, IDENT_R);
            send_request('{16'sh0100, 16'sh0200, -16'sh0300, 16'd10}, 1'b0, IDENT_R);
            wait_idle();
        end

        // Random samples over the idle phases and several scales
        for (int ph = 0; ph < 4; ph++)
        begin
            case (idle_phase_t'(ph))
                PH_NONE: begin send_idle_pct = 0; recv_idle_pct = 0; end
                PH_SEND: begin send_idle_pct = 85; recv_idle_pct = 0; end
                PH_RECV: begin send_idle_pct = 0; recv_idle_pct = 85; end
                default: begin send_idle_pct = 32; recv_idle_pct = 32; end
            endcase
            write_scale((ph == 3) ? $urandom : gqi_pkg::ANGLE_SCALE_RESET * (ph + 1));
            for (int n = 0; n < 100; n++)
                send_request(rand_sample(), 1'b0, IDENT_R);
            wait_idle();
        end

        if (errors == 0)
            $display("gyro_quaternion_integrator_unit test passed");
        else
            $display("gyro_quaternion_integrator_unit test failed");
        $finish;
    end
endmodule

`default_nettype wire
